@@ rtl/tcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and tables for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry and tab stop spacing
  localparam int NUM_COLUMNS = 80;
  localparam int NUM_LINES   = 25;
  localparam int TAB_WIDTH   = 8;

  localparam int CELL_COUNT = NUM_COLUMNS * NUM_LINES;
  localparam int FILL_BASE  = (NUM_LINES - 1) * NUM_COLUMNS;

  // Field widths of the command and result items
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFF_W  = 11;

  // Cell address and sweep counter widths
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  // Remaining store count, holds up to TAB_WIDTH
  localparam int REP_W  = $clog2(TAB_WIDTH + 1);

  // Command codes
  localparam logic [CMD_W-1:0] OP_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] OP_READ  = 2'd2;
  localparam logic [CMD_W-1:0] OP_MOVE  = 2'd3;

  // Character codes with special meaning
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'd11;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  // Column remainder modulo the tab width, indexed by column
  typedef logic [REP_W-1:0] rem_tab_t [0:(1<<COL_W)-1];

  function automatic rem_tab_t build_rem_tab();
    rem_tab_t t;
    for (int i = 0; i < (1 << COL_W); i++) begin
      t[i] = REP_W'(i % TAB_WIDTH);
    end
    return t;
  endfunction

  localparam rem_tab_t REM_TAB = build_rem_tab();

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic setup_put;
    logic store;
    logic newline;
    logic carriage;
    logic move;
    logic home;
    logic clr_start;
    logic clr_step;
    logic copy_start;
    logic copy_step;
    logic fill_step;
    logic read_issue;
    logic read_capture;
    logic emit;
  } tcw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [CHAR_W-1:0] ch;
    logic              in_range;
    logic              last_col;
    logic              last_row;
    logic              rep_last;
    logic              rep_zero;
    logic              sweep_last;
    logic              copy_done;
  } tcw_stat_t;

endpackage
`default_nettype wire

@@ rtl/tcw_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the console: decodes a command and steps the datapath.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire tcw_stat_t stat,
  output tcw_cmd_t       cmd
);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECODE = 4'd2;
  localparam logic [3:0] ST_STORE  = 4'd3;
  localparam logic [3:0] ST_COPY   = 4'd4;
  localparam logic [3:0] ST_FILL   = 4'd5;
  localparam logic [3:0] ST_CLEAR  = 4'd6;
  localparam logic [3:0] ST_READ   = 4'd7;
  localparam logic [3:0] ST_FINISH = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.op)
          OP_PUT: begin
            if (stat.ch == CH_NL) begin
              cmd.newline = 1'b1;
              if (stat.last_row) begin
                cmd.copy_start = 1'b1;
                state_nxt      = ST_COPY;
              end else begin
                state_nxt = ST_FINISH;
              end
            end else if (stat.ch == CH_CR) begin
              cmd.carriage = 1'b1;
              state_nxt    = ST_FINISH;
            end else begin
              cmd.setup_put = 1'b1;
              state_nxt     = ST_STORE;
            end
          end
          OP_CLEAR: begin
            cmd.home      = 1'b1;
            cmd.clr_start = 1'b1;
            state_nxt     = ST_CLEAR;
          end
          OP_READ: begin
            if (stat.in_range) begin
              cmd.read_issue = 1'b1;
              state_nxt      = ST_READ;
            end else begin
              state_nxt = ST_FINISH;
            end
          end
          default: begin
            cmd.move  = 1'b1;
            state_nxt = ST_FINISH;
          end
        endcase
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (stat.last_col && stat.last_row) begin
          cmd.copy_start = 1'b1;
          state_nxt      = ST_COPY;
        end else if (stat.rep_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_done) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.sweep_last) state_nxt = stat.rep_zero ? ST_FINISH : ST_STORE;
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) state_nxt = ST_FINISH;
      end
      ST_READ: begin
        cmd.read_capture = 1'b1;
        state_nxt        = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcw_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_dp
// Console datapath: cursor, command latch, sweep counter, screen RAM, result.
// ----------------------------------------------------------------------------
module tcw_dp
  import tcw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [CHAR_W-1:0] in_ch,
  input  wire logic [POS_W-1:0]  in_col,
  input  wire logic [POS_W-1:0]  in_row,
  input  wire tcw_cmd_t          cmd,
  output tcw_stat_t              stat,
  output logic                   out_valid,
  output logic [COL_W-1:0]       out_cursor_col,
  output logic [ROW_W-1:0]       out_cursor_row,
  output logic [OFF_W-1:0]       out_cursor_offset,
  output logic [CHAR_W-1:0]      out_read_char
);

  logic [CMD_W-1:0]  op_r,  op_nxt;
  logic [CHAR_W-1:0] ch_r,  ch_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [POS_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [CHAR_W-1:0] byte_r, byte_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cp_v_r, cp_v_nxt;
  logic [CHAR_W-1:0] rd_char_r, rd_char_nxt;
  logic              out_valid_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [OFF_W-1:0]  out_off_r;

  logic              in_range;
  logic              last_col;
  logic              last_row;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] pos_addr;
  logic [CNT_W-1:0]  copy_dst;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CHAR_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [CHAR_W-1:0] rdata;

  assign in_range = (col_r < POS_W'(NUM_COLUMNS)) && (row_r < POS_W'(NUM_LINES));
  assign last_col = (cur_col_r == COL_W'(NUM_COLUMNS - 1));
  assign last_row = (cur_row_r == ROW_W'(NUM_LINES - 1));
  assign cur_addr = ADDR_W'(cur_row_r * NUM_COLUMNS) + ADDR_W'(cur_col_r);
  assign pos_addr = ADDR_W'(row_r * NUM_COLUMNS) + ADDR_W'(col_r);
  // Data read last cycle came from cnt_r - 1; it lands one row higher
  assign copy_dst = cnt_r - CNT_W'(NUM_COLUMNS + 1);

  assign stat.op         = op_r;
  assign stat.ch         = ch_r;
  assign stat.in_range   = in_range;
  assign stat.last_col   = last_col;
  assign stat.last_row   = last_row;
  assign stat.rep_last   = (rep_r == REP_W'(1));
  assign stat.rep_zero   = (rep_r == '0);
  assign stat.sweep_last = (cnt_r == CNT_W'(CELL_COUNT - 1));
  assign stat.copy_done  = (cnt_r == CNT_W'(CELL_COUNT));

  // RAM port selection
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[ADDR_W-1:0];
    wdata = '0;
    if (cmd.store) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = byte_r;
    end else if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.fill_step) begin
      we    = 1'b1;
      wdata = CH_SPACE;
    end else if (cmd.copy_step && cp_v_r) begin
      we    = 1'b1;
      waddr = copy_dst[ADDR_W-1:0];
      wdata = rdata;
    end
  end

  always_comb begin
    if (cmd.read_issue) begin
      raddr = pos_addr;
    end else if (cnt_r < CNT_W'(CELL_COUNT)) begin
      raddr = cnt_r[ADDR_W-1:0];
    end else begin
      raddr = '0;
    end
  end

  tcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    op_nxt      = op_r;
    ch_nxt      = ch_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    byte_nxt    = byte_r;
    rep_nxt     = rep_r;
    cnt_nxt     = cnt_r;
    cp_v_nxt    = cp_v_r;
    rd_char_nxt = rd_char_r;

    if (cmd.load) begin
      op_nxt      = in_cmd;
      ch_nxt      = in_ch;
      col_nxt     = in_col;
      row_nxt     = in_row;
      rep_nxt     = '0;
      rd_char_nxt = '0;
    end

    if (cmd.setup_put) begin
      if (ch_r == CH_TAB) begin
        byte_nxt = CH_SPACE;
        rep_nxt  = REP_W'(TAB_WIDTH);
      end else if (ch_r == CH_VT) begin
        byte_nxt = CH_SPACE;
        rep_nxt  = REP_W'(TAB_WIDTH) - REM_TAB[cur_col_r];
      end else begin
        byte_nxt = ch_r;
        rep_nxt  = REP_W'(1);
      end
    end

    if (cmd.store) begin
      rep_nxt = rep_r - REP_W'(1);
      if (last_col) begin
        cur_col_nxt = '0;
        if (!last_row) cur_row_nxt = cur_row_r + ROW_W'(1);
      end else begin
        cur_col_nxt = cur_col_r + COL_W'(1);
      end
    end

    if (cmd.newline) begin
      cur_col_nxt = '0;
      if (!last_row) cur_row_nxt = cur_row_r + ROW_W'(1);
    end

    if (cmd.carriage) cur_col_nxt = '0;

    if (cmd.move && in_range) begin
      cur_col_nxt = col_r[COL_W-1:0];
      cur_row_nxt = row_r[ROW_W-1:0];
    end

    if (cmd.home) begin
      cur_col_nxt = '0;
      cur_row_nxt = '0;
    end

    if (cmd.clr_start) cnt_nxt = '0;
    if (cmd.clr_step || cmd.fill_step) cnt_nxt = cnt_r + CNT_W'(1);

    if (cmd.copy_start) begin
      cnt_nxt  = CNT_W'(NUM_COLUMNS);
      cp_v_nxt = 1'b0;
    end

    if (cmd.copy_step) begin
      if (cnt_r < CNT_W'(CELL_COUNT)) begin
        cnt_nxt  = cnt_r + CNT_W'(1);
        cp_v_nxt = 1'b1;
      end else begin
        cnt_nxt  = CNT_W'(FILL_BASE);
        cp_v_nxt = 1'b0;
      end
    end

    if (cmd.read_capture) rd_char_nxt = rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      rep_r       <= '0;
      cnt_r       <= '0;
      cp_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      rep_r       <= rep_nxt;
      cnt_r       <= cnt_nxt;
      cp_v_r      <= cp_v_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ch_r      <= ch_nxt;
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    byte_r    <= byte_nxt;
    rd_char_r <= rd_char_nxt;
    if (cmd.emit) begin
      out_col_r <= cur_col_r;
      out_row_r <= cur_row_r;
      out_off_r <= OFF_W'(cur_row_r * NUM_COLUMNS) + OFF_W'(cur_col_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_offset = out_off_r;
  assign out_read_char     = rd_char_r;

endmodule
`default_nettype wire

@@ rtl/text_console_writer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Character console with an 80x25 screen RAM, a cursor and scrolling.
// ----------------------------------------------------------------------------
// From the accepting edge, a newline, carriage return, move or out-of-range
// read passes the decode and finish states; a printable byte adds the store
// state and an in-range read the read state; each further tab space adds a
// store, each scroll adds a row copy plus a bottom-row fill over the
// one-write/one-read screen RAM, and clear adds a sweep of every cell.
// A new command is taken from the cycle the strobe is high (busy drops).
// After reset the screen RAM is zeroed, one cell a cycle, over all 2000 cells
// with busy high. Results cannot be stalled by the receiver.
module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [CHAR_W-1:0] in_ch,
  input  wire logic [POS_W-1:0]  in_col,
  input  wire logic [POS_W-1:0]  in_row,
  output logic                   out_valid,
  output logic [COL_W-1:0]       out_cursor_col,
  output logic [ROW_W-1:0]       out_cursor_row,
  output logic [OFF_W-1:0]       out_cursor_offset,
  output logic [CHAR_W-1:0]      out_read_char
);

  // Controller steps the datapath one command word per cycle
  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  // Sequencer: reset sweep, decode, store loop, scroll copy/fill, clear sweep, read, result
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath: latches the transfer, holds the cursor and the screen RAM,
  // and registers the result strobe
  tcw_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_cmd),
    .in_ch             (in_ch),
    .in_col            (in_col),
    .in_row            (in_row),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_row    (out_cursor_row),
    .out_cursor_offset (out_cursor_offset),
    .out_read_char     (out_read_char)
  );

endmodule
`default_nettype wire
